// ----- hw/rtl/edf_pkg.sv -----
// Shared types and constants for the EDF day scheduler.
// Used by edf_cell, edf_chain and edf_deadline_day_scheduler; no dependencies.
`default_nettype none

package edf_pkg;

  localparam int unsigned DAY_W      = 17;
  localparam int unsigned QDEPTH     = 64;
  localparam int unsigned CNT_W      = $clog2(QDEPTH + 1);
  localparam int unsigned OUT_CNT_W  = 7;
  localparam int unsigned TOT_W      = 17;

  typedef logic [DAY_W-1:0] day_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam day_t                DAY_MAX       = {DAY_W{1'b1}};
  localparam day_t                FIRST_DAY_RST = day_t'(1);
  localparam logic [TOT_W-1:0]    TOTAL_MAX     = {TOT_W{1'b1}};

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic req_type;
    day_t end_day;
  } in_item_t;

  typedef struct packed {
    logic                 status;
    logic                 attended;
    day_t                 served_deadline;
    logic [OUT_CNT_W-1:0] dropped_count;
    logic [TOT_W-1:0]     total_attended;
    logic [OUT_CNT_W-1:0] occupancy;
  } out_item_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic insert;  // sorted insert of the broadcast deadline
    logic shift;   // every cell takes its right neighbor (pop head)
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/edf_cell.sv -----
// One cell of the sorted deadline chain: holds a single deadline.
// Depends on edf_pkg.
`default_nettype none

module edf_cell (
  input  wire                 clk_i,
  input  edf_pkg::cell_ctl_t  ctl_i,
  input  edf_pkg::day_t       new_i,
  input  wire                 occ_i,       // cell currently holds a deadline
  input  wire                 bef_left_i,  // new value goes at or before left cell
  input  edf_pkg::day_t       left_i,
  input  edf_pkg::day_t       right_i,
  output logic                bef_o,
  output edf_pkg::day_t       val_o
);

  edf_pkg::day_t val_q, val_d;

  // new deadline belongs here or further left
  assign bef_o = !occ_i || (new_i < val_q);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.insert && bef_o) begin
      val_d = bef_left_i ? left_i : new_i;
    end else if (ctl_i.shift) begin
      val_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/edf_chain.sv -----
// Row of edf_cell instances kept sorted ascending; cell 0 is the minimum.
// Depends on edf_pkg and edf_cell.
`default_nettype none

module edf_chain (
  input  wire                 clk_i,
  input  edf_pkg::cell_ctl_t  ctl_i,
  input  edf_pkg::day_t       new_i,
  input  edf_pkg::cnt_t       count_i,
  output edf_pkg::day_t       head_o
);

  edf_pkg::day_t               val [edf_pkg::QDEPTH];
  logic [edf_pkg::QDEPTH-1:0]  bef;
  logic [edf_pkg::QDEPTH-1:0]  occ;

  for (genvar i = 0; i < edf_pkg::QDEPTH; i++) begin : g_cell
    edf_pkg::day_t left_v, right_v;
    logic          bef_left;

    // occupied cells form a prefix of length count
    assign occ[i] = count_i > edf_pkg::cnt_t'(i);

    if (i == 0) begin : g_first
      assign left_v   = '0;
      assign bef_left = 1'b0;
    end else begin : g_mid
      assign left_v   = val[i-1];
      assign bef_left = bef[i-1];
    end

    if (i == edf_pkg::QDEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = val[i+1];
    end

    edf_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl_i),
      .new_i      (new_i),
      .occ_i      (occ[i]),
      .bef_left_i (bef_left),
      .left_i     (left_v),
      .right_i    (right_v),
      .bef_o      (bef[i]),
      .val_o      (val[i])
    );
  end

  assign head_o = val[0];

endmodule

`default_nettype wire

// ----- hw/rtl/edf_deadline_day_scheduler.sv -----
// EDF day scheduler: sorted cell chain of deadlines, minimum at the head.
// Add: insert in the accept cycle, then result load once the output reg is free.
// Tick: expired heads dropped one per cycle, then serve, then result load.
// One transaction in flight; the next is accepted while a result waits in the output reg.
// Reset (async, active low): queue empty, day = 1, total = 0, no result pending.
// Depends on edf_pkg, edf_chain, edf_cell.
`default_nettype none

module edf_deadline_day_scheduler (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // configuration: first_day
  input  wire                 cfg_we_i,
  input  edf_pkg::day_t       cfg_data_i,
  // request channel
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  edf_pkg::in_item_t   in_item_i,
  // result channel
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output edf_pkg::out_item_t  out_item_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,  // waiting for a transaction
    ST_DROP = 3'b010,  // tick: drop expired heads, then serve the head
    ST_FIN  = 3'b100   // result ready, waiting for the output register
  } state_e;

  state_e              state_q, state_d;
  edf_pkg::cnt_t       count_q, count_d;
  edf_pkg::day_t       day_q, day_d;
  logic [edf_pkg::TOT_W-1:0] total_q, total_d;
  edf_pkg::cnt_t       drop_q, drop_d;
  edf_pkg::out_item_t  pend_q, pend_d;
  edf_pkg::out_item_t  out_q, out_d;
  logic                out_valid_q, out_valid_d;

  edf_pkg::cell_ctl_t  ctl;
  edf_pkg::day_t       head;
  logic                head_vld;
  logic                head_exp;
  logic                out_free;

  edf_chain u_chain (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .new_i   (in_item_i.end_day),
    .count_i (count_q),
    .head_o  (head)
  );

  assign head_vld = count_q != '0;
  // chain is sorted, so expired deadlines always sit at the head
  assign head_exp = head_vld && (head < day_q);
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    day_d       = day_q;
    total_d     = total_q;
    drop_d      = drop_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctl         = '0;

    // first_day write reloads the day counter; the user must write it only while idle (not enforced here)
    if (cfg_we_i) begin
      day_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.req_type == edf_pkg::REQ_TICK) begin
            drop_d  = '0;
            state_d = ST_DROP;
          end else begin
            pend_d = '0;
            if (count_q == edf_pkg::cnt_t'(edf_pkg::QDEPTH)) begin
              pend_d.status = edf_pkg::STATUS_FULL;
            end else begin
              pend_d.status = edf_pkg::STATUS_OK;
              ctl.insert    = 1'b1;
              count_d       = count_q + edf_pkg::cnt_t'(1);
            end
            pend_d.total_attended = total_q;
            pend_d.occupancy      = edf_pkg::OUT_CNT_W'(count_d);
            state_d               = ST_FIN;
          end
        end
      end

      ST_DROP: begin
        if (head_exp) begin
          ctl.shift = 1'b1;
          count_d   = count_q - edf_pkg::cnt_t'(1);
          drop_d    = drop_q + edf_pkg::cnt_t'(1);
        end else begin
          pend_d               = '0;
          pend_d.dropped_count = edf_pkg::OUT_CNT_W'(drop_q);
          if (head_vld) begin
            // serve earliest live deadline
            ctl.shift                = 1'b1;
            count_d                  = count_q - edf_pkg::cnt_t'(1);
            pend_d.attended          = 1'b1;
            pend_d.served_deadline   = head;
            if (total_q != edf_pkg::TOTAL_MAX) begin
              total_d = total_q + edf_pkg::TOT_W'(1);
            end
          end
          pend_d.total_attended = total_d;
          pend_d.occupancy      = edf_pkg::OUT_CNT_W'(count_d);
          if (day_q != edf_pkg::DAY_MAX) begin
            day_d = day_q + edf_pkg::day_t'(1);
          end
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      day_q       <= edf_pkg::FIRST_DAY_RST;
      total_q     <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      day_q       <= day_d;
      total_q     <= total_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // occupancy never exceeds the chain length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= edf_pkg::cnt_t'(edf_pkg::QDEPTH))
    else $error("occupancy above queue depth");

  // an accepted tick always enters the drop phase
  a_tick_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_item_i.req_type == edf_pkg::REQ_TICK)
      |=> (state_q == ST_DROP))
    else $error("tick did not enter drop phase");

  // a new result only appears after the finish state
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result appeared outside finish state");

  // chain never inserts and pops in the same cycle
  a_ctl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.insert && ctl.shift))
    else $error("insert and shift together");

endmodule

`default_nettype wire
